[design/mte_pkg.sv]
`default_nettype none

package mte_pkg;

    // field widths fixed by the interface
    localparam int KEY_W   = 4;
    localparam int TAP_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 6;
    localparam int TICK_W  = 16;
    localparam int EV_W    = 2;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd80;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // result codes
    localparam logic [EV_W-1:0] EV_APPEND = 2'd0;
    localparam logic [EV_W-1:0] EV_REMOVE = 2'd1;
    localparam logic [EV_W-1:0] EV_SENT   = 2'd2;
    localparam logic [EV_W-1:0] EV_CLOSE  = 2'd3;

    // key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_SEND      = 4'd10;
    localparam logic [KEY_W-1:0] KEY_BACK      = 4'd11;

    // classified operation passed from front to back
    typedef enum logic [1:0] {
        OP_TICK,
        OP_DIGIT,
        OP_SEND,
        OP_BACK
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } cmd_t;

    // number of characters on a digit key
    function automatic logic [TAP_W-1:0] key_count(input logic [KEY_W-1:0] k);
        logic [TAP_W-1:0] c;
        case (k)
            4'd0:    c = 3'd2;
            4'd1:    c = 3'd5;
            4'd7:    c = 3'd5;
            4'd9:    c = 3'd5;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

    // character shown for a key at a given tap position
    function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] k,
                                                   input logic [TAP_W-1:0] tap);
        logic [39:0]       row;
        logic [TAP_W-1:0]  cnt;
        logic [TAP_W-1:0]  t;
        logic [TAP_W-1:0]  sh;
        logic [39:0]       shifted;
        case (k)
            4'd0:    row = 40'(" 0");
            4'd1:    row = 40'(".,!?1");
            4'd2:    row = 40'("abc2");
            4'd3:    row = 40'("def3");
            4'd4:    row = 40'("ghi4");
            4'd5:    row = 40'("jkl5");
            4'd6:    row = 40'("mno6");
            4'd7:    row = 40'("pqrs7");
            4'd8:    row = 40'("tuv8");
            4'd9:    row = 40'("wxyz9");
            default: row = 40'(" 0");
        endcase
        cnt     = key_count((k <= KEY_DIGIT_MAX) ? k : 4'd0);
        t       = (tap < cnt) ? tap : 3'd0;
        sh      = 3'(cnt - 3'd1 - t);
        shifted = row >> {sh, 3'b000};
        return shifted[CHAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/mte_ram.sv]
`default_nettype none

module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/mte_front.sv]
`default_nettype none

module mte_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic [mte_pkg::KEY_W-1:0]  key,
    input  wire logic                       pressed,
    output logic                            cmd_valid,
    output mte_pkg::cmd_t                   cmd,
    input  wire logic                       cmd_pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = 1;
    localparam int CNT_W  = 2;

    mte_pkg::cmd_t    q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             is_cmd;
    mte_pkg::cmd_t    new_cmd;
    logic             push;

    // classify the incoming beat; releases and unused keys are dropped
    always_comb
    begin
        is_cmd      = 1'b0;
        new_cmd.op  = mte_pkg::OP_TICK;
        new_cmd.key = key;
        if (!mode)
        begin
            is_cmd = 1'b1;
        end
        else if (pressed)
        begin
            case (key) inside
                [4'd0:mte_pkg::KEY_DIGIT_MAX]:
                begin
                    is_cmd     = 1'b1;
                    new_cmd.op = mte_pkg::OP_DIGIT;
                end
                mte_pkg::KEY_SEND:
                begin
                    is_cmd     = 1'b1;
                    new_cmd.op = mte_pkg::OP_SEND;
                end
                mte_pkg::KEY_BACK:
                begin
                    is_cmd     = 1'b1;
                    new_cmd.op = mte_pkg::OP_BACK;
                end
                default:
                begin
                    is_cmd = 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = (cnt_reg != CNT_W'(QDEPTH));
    assign push      = in_valid && in_ready && is_cmd;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

[design/mte_back.sv]
`default_nettype none

module mte_back #(
    parameter int MAX_CHARS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mte_pkg::TICK_W-1:0]  cfg_wr_data,
    input  wire logic                        cmd_valid,
    input  wire mte_pkg::cmd_t               cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mte_pkg::EV_W-1:0]         event_res,
    output logic [mte_pkg::CHAR_W-1:0]       char_code,
    output logic                             last,
    output logic [mte_pkg::LEN_W-1:0]        length
);

    localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int LEN_W = mte_pkg::LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RMV   = 4'b0010,
        S_CLOSE = 4'b0100,
        S_SEND  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [LEN_W-1:0]                len_reg, len_next;
    logic                            pend_reg, pend_next;
    logic [mte_pkg::KEY_W-1:0]       pkey_reg, pkey_next;
    logic [mte_pkg::TAP_W-1:0]       tap_reg, tap_next;
    logic [mte_pkg::TICK_W-1:0]      elapsed_reg, elapsed_next;
    logic [mte_pkg::TICK_W-1:0]      timeout_reg, timeout_next;
    logic [LEN_W-1:0]                rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]                emit_idx_reg, emit_idx_next;
    logic                            dv_reg, dv_next;

    logic                            out_valid_reg, out_valid_next;
    logic [mte_pkg::EV_W-1:0]        event_res_reg, event_res_next;
    logic [mte_pkg::CHAR_W-1:0]      char_code_reg, char_code_next;
    logic                            last_reg, last_next;
    logic [LEN_W-1:0]                length_reg, length_next;

    logic                            ram_we;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [mte_pkg::CHAR_W-1:0]      ram_rdata;

    logic                            can_emit;
    logic                            room;
    logic                            can_commit;
    logic [mte_pkg::CHAR_W-1:0]      pend_char;
    logic [mte_pkg::TICK_W-1:0]      tick_inc;
    logic [mte_pkg::TAP_W-1:0]       tap_inc;
    logic [LEN_W-1:0]                len_inc;
    logic [LEN_W-1:0]                len_dec;
    logic                            do_emit;
    logic                            issue;
    logic                            emit_last;

    assign can_emit   = !out_valid_reg || out_ready;
    assign room       = (len_reg < MAX_LEN);
    assign can_commit = pend_reg && room;
    assign pend_char  = mte_pkg::key_char(pkey_reg, tap_reg);
    assign tick_inc   = (elapsed_reg != mte_pkg::TICK_MAX)
                        ? mte_pkg::TICK_W'(elapsed_reg + 1'b1) : elapsed_reg;
    assign tap_inc    = mte_pkg::TAP_W'(tap_reg + 1'b1);
    assign len_inc    = LEN_W'(len_reg + 1'b1);
    assign len_dec    = LEN_W'(len_reg - 1'b1);
    assign do_emit    = dv_reg && can_emit;
    assign issue      = (rd_idx_reg < len_reg) && (!dv_reg || do_emit);
    assign emit_last  = (emit_idx_reg == len_dec);

    // compose buffer
    mte_ram #(
        .WIDTH (mte_pkg::CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (pend_char),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: carries out one command, emits one result beat per cycle while out_ready does not stall it
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        pkey_next      = pkey_reg;
        tap_next       = tap_reg;
        elapsed_next   = elapsed_reg;
        timeout_next   = cfg_wr_en ? cfg_wr_data : timeout_reg;
        rd_idx_next    = rd_idx_reg;
        emit_idx_next  = emit_idx_reg;
        dv_next        = dv_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg[AW-1:0];

        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        event_res_next = event_res_reg;
        char_code_next = char_code_reg;
        last_next      = last_reg;
        length_next    = length_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && can_emit)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        mte_pkg::OP_TICK:
                        begin
                            elapsed_next = tick_inc;
                            if (can_commit && (tick_inc >= timeout_reg))
                            begin
                                ram_we         = 1'b1;
                                len_next       = len_inc;
                                pend_next      = 1'b0;
                                pkey_next      = '0;
                                tap_next       = '0;
                                out_valid_next = 1'b1;
                                event_res_next = mte_pkg::EV_APPEND;
                                char_code_next = pend_char;
                                last_next      = 1'b1;
                                length_next    = len_inc;
                            end
                        end
                        mte_pkg::OP_DIGIT:
                        begin
                            elapsed_next = '0;
                            if (pend_reg && (pkey_reg == cmd.key))
                            begin
                                // same key again: next character on the key
                                tap_next = (tap_inc >= mte_pkg::key_count(cmd.key))
                                           ? '0 : tap_inc;
                            end
                            else
                            begin
                                if (can_commit)
                                begin
                                    ram_we         = 1'b1;
                                    len_next       = len_inc;
                                    out_valid_next = 1'b1;
                                    event_res_next = mte_pkg::EV_APPEND;
                                    char_code_next = pend_char;
                                    last_next      = 1'b1;
                                    length_next    = len_inc;
                                end
                                pend_next = 1'b1;
                                pkey_next = cmd.key;
                                tap_next  = '0;
                            end
                        end
                        mte_pkg::OP_SEND:
                        begin
                            rd_idx_next   = '0;
                            emit_idx_next = '0;
                            dv_next       = 1'b0;
                            if (can_commit)
                            begin
                                ram_we         = 1'b1;
                                len_next       = len_inc;
                                pend_next      = 1'b0;
                                pkey_next      = '0;
                                tap_next       = '0;
                                out_valid_next = 1'b1;
                                event_res_next = mte_pkg::EV_APPEND;
                                char_code_next = pend_char;
                                last_next      = 1'b0;
                                length_next    = len_inc;
                                state_next     = S_SEND;
                            end
                            else if (len_reg != '0)
                            begin
                                state_next = S_SEND;
                            end
                        end
                        mte_pkg::OP_BACK:
                        begin
                            if (len_reg != '0)
                            begin
                                // drop pending, fetch the last character
                                pend_next  = 1'b0;
                                pkey_next  = '0;
                                tap_next   = '0;
                                len_next   = len_dec;
                                ram_re     = 1'b1;
                                ram_raddr  = len_dec[AW-1:0];
                                state_next = S_RMV;
                            end
                            else if (can_commit)
                            begin
                                ram_we         = 1'b1;
                                len_next       = len_inc;
                                pend_next      = 1'b0;
                                pkey_next      = '0;
                                tap_next       = '0;
                                out_valid_next = 1'b1;
                                event_res_next = mte_pkg::EV_APPEND;
                                char_code_next = pend_char;
                                last_next      = 1'b0;
                                length_next    = len_inc;
                                state_next     = S_CLOSE;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                event_res_next = mte_pkg::EV_CLOSE;
                                char_code_next = '0;
                                last_next      = 1'b1;
                                length_next    = len_reg;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RMV:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    event_res_next = mte_pkg::EV_REMOVE;
                    char_code_next = ram_rdata;
                    last_next      = 1'b1;
                    length_next    = len_reg;
                    state_next     = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    event_res_next = mte_pkg::EV_CLOSE;
                    char_code_next = '0;
                    last_next      = 1'b1;
                    length_next    = len_reg;
                    state_next     = S_IDLE;
                end
            end
            S_SEND:
            begin
                // read one entry ahead of the beat being emitted
                ram_re  = issue;
                dv_next = issue || (dv_reg && !do_emit);
                if (issue)
                begin
                    rd_idx_next = LEN_W'(rd_idx_reg + 1'b1);
                end
                if (do_emit)
                begin
                    out_valid_next = 1'b1;
                    event_res_next = mte_pkg::EV_SENT;
                    char_code_next = ram_rdata;
                    last_next      = emit_last;
                    length_next    = LEN_W'(len_dec - emit_idx_reg);
                    emit_idx_next  = LEN_W'(emit_idx_reg + 1'b1);
                    if (emit_last)
                    begin
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            pkey_reg      <= '0;
            tap_reg       <= '0;
            elapsed_reg   <= '0;
            timeout_reg   <= mte_pkg::TIMEOUT_RESET;
            rd_idx_reg    <= '0;
            emit_idx_reg  <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            pkey_reg      <= pkey_next;
            tap_reg       <= tap_next;
            elapsed_reg   <= elapsed_next;
            timeout_reg   <= timeout_next;
            rd_idx_reg    <= rd_idx_next;
            emit_idx_reg  <= emit_idx_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        event_res_reg <= event_res_next;
        char_code_reg <= char_code_next;
        last_reg      <= last_next;
        length_reg    <= length_next;
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign char_code = char_code_reg;
    assign last      = last_reg;
    assign length    = length_reg;

endmodule

`default_nettype wire

[design/multitap_text_entry_core.sv]
// Multi-tap keypad text entry. Input beats are 10 ms ticks or key events; a
// front stage classifies them into a two-entry command queue, dropping
// releases and unused keys, and a back sequencer carries each command out
// against a compose buffer of MAX_CHARS characters held in a RAM. Ticks and
// digit presses are carried out in the idle state of the sequencer; back
// reads the removed character from the RAM before emitting it; send starts
// in idle, then streams the buffer at one result beat per cycle, with the RAM
// read running one entry ahead. Result beats are held in an output register
// and stall the sequencer only while out_ready is low. The timeout register
// is written through cfg_wr_en/cfg_wr_data and resets to 80 ticks.
`default_nettype none

module multitap_text_entry_core #(
    parameter int MAX_CHARS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mte_pkg::TICK_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [mte_pkg::KEY_W-1:0]   key,
    input  wire logic                        pressed,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mte_pkg::EV_W-1:0]         event_res,
    output logic [mte_pkg::CHAR_W-1:0]       char_code,
    output logic                             last,
    output logic [mte_pkg::LEN_W-1:0]        length
);

    logic          cmd_valid;
    mte_pkg::cmd_t cmd;
    logic          cmd_pop;

    // classify and queue
    mte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .pressed   (pressed),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // execute and emit results
    mte_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .char_code   (char_code),
        .last        (last),
        .length      (length)
    );

endmodule

`default_nettype wire
